[rtl/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants of the reorder buffer with in-order commit.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int ROB_DEPTH  = 64;
  localparam int MAX_RETIRE = 8;

  localparam int PTR_W = $clog2(ROB_DEPTH);
  localparam int OCC_W = $clog2(ROB_DEPTH + 1);
  localparam int LIM_W = $clog2(MAX_RETIRE + 1);
  localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;
  localparam int TAG_W = 6;
  localparam int TCMP_W = ((PTR_W > TAG_W) ? PTR_W : TAG_W) + 1;

  localparam logic [3:0] RETIRE_WIDTH_RST = 4'd4;

  // input kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  // result kinds
  localparam logic [2:0] OUT_ALLOC   = 3'd0;
  localparam logic [2:0] OUT_RETIRE  = 3'd1;
  localparam logic [2:0] OUT_WAKE    = 3'd2;
  localparam logic [2:0] OUT_SUMMARY = 3'd3;
  localparam logic [2:0] OUT_FLUSH   = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      inst_id;
    logic             is_store;
    logic             is_branch;
    logic [TAG_W-1:0] finish_tag;
    logic             mispredicted;
  } rbc_item_t;

  typedef struct packed {
    logic [2:0]       out_kind;
    logic [15:0]      out_inst_id;
    logic [TAG_W-1:0] slot_tag;
    logic             retired_is_branch;
    logic             redirect;
    logic [6:0]       credit;
    logic             overflow;
    logic             last;
  } rbc_result_t;

  // entry payload: written on allocate, woken mark rewritten on commit
  typedef struct packed {
    logic [15:0] id;
    logic        store;
    logic        branch;
    logic        woken;
  } rbc_pay_t;

  // entry status: written on allocate and finish
  typedef struct packed {
    logic done;
    logic mispredict;
  } rbc_sta_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } rbc_mem_ctl_t;

endpackage

[rtl/rbc_ram.sv]
// ----------------------------------------------------------------------------
// rbc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rbc_ctrl.sv]
// ----------------------------------------------------------------------------
// rbc_ctrl
// Pointer state and commit sequencer; drives the two entry memories.
// ----------------------------------------------------------------------------
module rbc_ctrl
  import rbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  rbc_item_t    item,
  input  logic [3:0]   retire_width,
  input  logic         out_free,
  output logic         emit,
  output rbc_result_t  emit_word,
  output rbc_mem_ctl_t pay_ctl,
  output rbc_pay_t     pay_wdata,
  input  rbc_pay_t     pay_rdata,
  output rbc_mem_ctl_t sta_ctl,
  output rbc_sta_t     sta_wdata,
  input  rbc_sta_t     sta_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EVAL = 5'b00100,
    S_WAKE = 5'b01000,
    S_SUM  = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [LIM_W-1:0] limit, limit_next;
  logic [LIM_W-1:0] count, count_next;
  logic             redir, redir_next;

  logic             accept;
  logic             full;
  logic [CMP_W-1:0] rw_ext, occ_ext, cap;
  logic [PTR_W-1:0] head_inc, tail_inc;

  assign item_ready = (state == S_IDLE) && out_free;
  assign accept     = item_valid && item_ready;
  assign full       = (occ == OCC_W'(ROB_DEPTH));
  assign head_inc   = (head == PTR_W'(ROB_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc   = (tail == PTR_W'(ROB_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  assign rw_ext     = CMP_W'(retire_width);
  assign occ_ext    = CMP_W'(occ);
  assign cap        = (rw_ext > CMP_W'(MAX_RETIRE)) ? CMP_W'(MAX_RETIRE) : rw_ext;

  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    occ_next   = occ;
    limit_next = limit;
    count_next = count;
    redir_next = redir;
    emit       = 1'b0;
    emit_word  = '0;
    pay_ctl    = '0;
    pay_wdata  = '0;
    sta_ctl    = '0;
    sta_wdata  = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_ALLOC: begin
              emit           = 1'b1;
              emit_word.last = 1'b1;
              if (full) begin
                emit_word.overflow = 1'b1;
              end else begin
                pay_ctl.wr_en      = 1'b1;
                pay_ctl.wr_addr    = tail;
                pay_wdata.id       = item.inst_id;
                pay_wdata.store    = item.is_store;
                pay_wdata.branch   = item.is_branch;
                sta_ctl.wr_en      = 1'b1;
                sta_ctl.wr_addr    = tail;
                emit_word.slot_tag = TAG_W'(tail);
                tail_next          = tail_inc;
                occ_next           = occ + OCC_W'(1);
              end
            end
            KIND_FINISH: begin
              if (TCMP_W'(item.finish_tag) < TCMP_W'(ROB_DEPTH)) begin
                sta_ctl.wr_en        = 1'b1;
                sta_ctl.wr_addr      = PTR_W'(item.finish_tag);
                sta_wdata.done       = 1'b1;
                sta_wdata.mispredict = item.mispredicted;
              end
            end
            KIND_COMMIT: begin
              limit_next = LIM_W'((cap > occ_ext) ? occ_ext : cap);
              count_next = '0;
              redir_next = 1'b0;
              state_next = S_READ;
            end
            KIND_FLUSH: begin
              head_next          = '0;
              tail_next          = '0;
              occ_next           = '0;
              emit               = 1'b1;
              emit_word.out_kind = OUT_FLUSH;
              emit_word.credit   = 7'(ROB_DEPTH);
              emit_word.last     = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        pay_ctl.rd_en   = 1'b1;
        pay_ctl.rd_addr = head;
        sta_ctl.rd_en   = 1'b1;
        sta_ctl.rd_addr = head;
        state_next      = S_EVAL;
      end

      S_EVAL: begin
        if ((count < limit) && sta_rdata.done) begin
          if (out_free) begin
            emit                        = 1'b1;
            emit_word.out_kind          = OUT_RETIRE;
            emit_word.out_inst_id       = pay_rdata.id;
            emit_word.slot_tag          = TAG_W'(head);
            emit_word.retired_is_branch = pay_rdata.branch;
            emit_word.redirect          = sta_rdata.mispredict;
            count_next                  = count + LIM_W'(1);
            if (sta_rdata.mispredict) begin
              // hold the head; retirement stops here
              redir_next = 1'b1;
              state_next = S_WAKE;
            end else begin
              head_next  = head_inc;
              occ_next   = occ - OCC_W'(1);
              state_next = S_READ;
            end
          end
        end else begin
          state_next = S_WAKE;
        end
      end

      S_WAKE: begin
        if ((occ != '0) && pay_rdata.store && !pay_rdata.woken) begin
          if (out_free) begin
            emit                  = 1'b1;
            emit_word.out_kind    = OUT_WAKE;
            emit_word.out_inst_id = pay_rdata.id;
            emit_word.slot_tag    = TAG_W'(head);
            pay_ctl.wr_en         = 1'b1;
            pay_ctl.wr_addr       = head;
            pay_wdata             = pay_rdata;
            pay_wdata.woken       = 1'b1;
            state_next            = S_SUM;
          end
        end else begin
          state_next = S_SUM;
        end
      end

      S_SUM: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_word.out_kind = OUT_SUMMARY;
          emit_word.redirect = redir;
          emit_word.credit   = 7'(count);
          emit_word.last     = 1'b1;
          state_next         = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
      limit <= '0;
      count <= '0;
      redir <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      limit <= limit_next;
      count <= count_next;
      redir <= redir_next;
    end
  end

endmodule

[rtl/reorder_buffer_commit.sv]
// ----------------------------------------------------------------------------
// reorder_buffer_commit
// Circular reorder buffer with in-order commit, store wakeup and flush.
// ----------------------------------------------------------------------------
// Channels: item words (item_valid/item_ready) carry allocate, finish,
// commit tick and flush requests; result words (result_valid/result_ready)
// carry alloc tags, retired entries, store wakeups, commit summaries and
// flush acks, the final word of each answered request marked by last. The cfg
// channel writes retire_width and is always ready.
// Sequencing: allocate, finish and flush are handled in the accepting cycle,
// their result registered at the accepting edge. A commit tick is accepted,
// then each head entry examined takes a memory read state and a decide
// state, followed by the wakeup check and the summary. The registered read
// of the entry memories is why each entry needs its own read state; one
// request is in flight at a time.
// Reset: pointers and occupancy clear and retire_width returns to 4; the
// entry memories need no clearing pass, as every entry is rewritten on
// allocate before it is read.
// Stall: a held result word stops the sequencer until it is taken; a new
// request is accepted in the same cycle that the last result leaves.
// ----------------------------------------------------------------------------
module reorder_buffer_commit
  import rbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  rbc_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output rbc_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic         [3:0] retire_width;
  logic               out_free;
  logic               emit;
  rbc_result_t        emit_word;
  rbc_mem_ctl_t       pay_ctl, sta_ctl;
  rbc_pay_t           pay_wdata, pay_rdata;
  rbc_sta_t           sta_wdata, sta_rdata;

  // configuration: always accept; to be written only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      retire_width <= RETIRE_WIDTH_RST;
    end else if (cfg_valid) begin
      retire_width <= cfg_data;
    end
  end

  // output register: free when empty or being taken this cycle
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_word;
    end
  end

  rbc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .retire_width (retire_width),
    .out_free     (out_free),
    .emit         (emit),
    .emit_word    (emit_word),
    .pay_ctl      (pay_ctl),
    .pay_wdata    (pay_wdata),
    .pay_rdata    (pay_rdata),
    .sta_ctl      (sta_ctl),
    .sta_wdata    (sta_wdata),
    .sta_rdata    (sta_rdata)
  );

  // entry id, store/branch marks and woken mark
  rbc_ram #(
    .WIDTH ($bits(rbc_pay_t)),
    .DEPTH (ROB_DEPTH)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_ctl.wr_en),
    .wr_addr (pay_ctl.wr_addr),
    .wr_data (pay_wdata),
    .rd_en   (pay_ctl.rd_en),
    .rd_addr (pay_ctl.rd_addr),
    .rd_data (pay_rdata)
  );

  // done and mispredict flags
  rbc_ram #(
    .WIDTH ($bits(rbc_sta_t)),
    .DEPTH (ROB_DEPTH)
  ) u_sta_ram (
    .clk     (clk),
    .wr_en   (sta_ctl.wr_en),
    .wr_addr (sta_ctl.wr_addr),
    .wr_data (sta_wdata),
    .rd_en   (sta_ctl.rd_en),
    .rd_addr (sta_ctl.rd_addr),
    .rd_data (sta_rdata)
  );

  // a result word is only produced into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result produced while output register held");

  // a commit tick blocks further requests for at least the next cycle
  a_commit_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.kind == KIND_COMMIT)) |=> !item_ready)
    else $error("request accepted during commit");

  // a flush is answered by a final flush ack in the next cycle
  a_flush_ack: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.kind == KIND_FLUSH)) |=>
      (result_valid && (result.out_kind == OUT_FLUSH) && result.last))
    else $error("flush not acknowledged");

  // the memories are never written together except on allocate
  a_dual_write: assert property (@(posedge clk) disable iff (rst)
    (pay_ctl.wr_en && sta_ctl.wr_en) |-> (emit && (emit_word.out_kind == OUT_ALLOC)))
    else $error("unexpected dual memory write");

endmodule

[verif/rbc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbc_checker
// Watches the item, result and cfg channels of the reorder buffer, keeps its
// own copy of the ring and predicts every result word in order.
// ----------------------------------------------------------------------------
module rbc_checker
  import rbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  rbc_item_t   item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  rbc_result_t result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          items_seen,
  output int          words_seen,
  output int          overflows_seen,
  output int          redirects_seen,
  output int          wakeups_seen
);

  // shadow ring
  bit [15:0]   slot_id     [ROB_DEPTH];
  bit          slot_done   [ROB_DEPTH];
  bit          slot_store  [ROB_DEPTH];
  bit          slot_branch [ROB_DEPTH];
  bit          slot_misp   [ROB_DEPTH];
  bit          slot_woken  [ROB_DEPTH];
  int          head_slot;
  int          tail_slot;
  int          fill;
  logic [3:0]  retire_width;

  rbc_result_t pending_words [$];

  function automatic int step_slot(int p);
    return (p + 1 >= ROB_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic clear_ring();
    for (int s = 0; s < ROB_DEPTH; s++) begin
      slot_done[s]   = 1'b0;
      slot_store[s]  = 1'b0;
      slot_branch[s] = 1'b0;
      slot_misp[s]   = 1'b0;
      slot_woken[s]  = 1'b0;
    end
    head_slot = 0;
    tail_slot = 0;
    fill      = 0;
  endtask

  // work out the result words of one accepted item and queue them
  task automatic predict_words(input rbc_item_t w);
    rbc_result_t r;
    int          limit;
    int          count;
    int          h;
    bit          redir;
    r      = '0;
    r.last = 1'b1;
    case (w.kind)
      KIND_ALLOC: begin
        r.out_kind = OUT_ALLOC;
        if (fill >= ROB_DEPTH) begin
          r.overflow = 1'b1;
          overflows_seen++;
        end else begin
          slot_id[tail_slot]     = w.inst_id;
          slot_store[tail_slot]  = w.is_store;
          slot_branch[tail_slot] = w.is_branch;
          slot_done[tail_slot]   = 1'b0;
          slot_misp[tail_slot]   = 1'b0;
          slot_woken[tail_slot]  = 1'b0;
          r.slot_tag = TAG_W'(tail_slot);
          tail_slot  = step_slot(tail_slot);
          fill++;
        end
        pending_words.push_back(r);
      end
      KIND_FINISH: begin
        if (w.finish_tag < ROB_DEPTH) begin
          slot_done[w.finish_tag] = 1'b1;
          slot_misp[w.finish_tag] = w.mispredicted;
        end
      end
      KIND_COMMIT: begin
        limit = (retire_width > MAX_RETIRE) ? MAX_RETIRE : int'(retire_width);
        if (limit > fill) limit = fill;
        count = 0;
        redir = 1'b0;
        while (count < limit) begin
          h = head_slot;
          if (!slot_done[h]) break;
          r                   = '0;
          r.out_kind          = OUT_RETIRE;
          r.out_inst_id       = slot_id[h];
          r.slot_tag          = TAG_W'(h);
          r.retired_is_branch = slot_branch[h];
          r.redirect          = slot_misp[h];
          pending_words.push_back(r);
          count++;
          // a mispredicted head is reported but stays put
          if (slot_misp[h]) begin
            redir = 1'b1;
            redirects_seen++;
            break;
          end
          head_slot = step_slot(h);
          fill--;
        end
        if (fill > 0 && slot_store[head_slot] && !slot_woken[head_slot]) begin
          slot_woken[head_slot] = 1'b1;
          r             = '0;
          r.out_kind    = OUT_WAKE;
          r.out_inst_id = slot_id[head_slot];
          r.slot_tag    = TAG_W'(head_slot);
          pending_words.push_back(r);
          wakeups_seen++;
        end
        r          = '0;
        r.out_kind = OUT_SUMMARY;
        r.redirect = redir;
        r.credit   = 7'(count);
        r.last     = 1'b1;
        pending_words.push_back(r);
      end
      default: begin
        clear_ring();
        r.out_kind = OUT_FLUSH;
        r.credit   = 7'(ROB_DEPTH);
        pending_words.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    rbc_result_t want;
    if (rst) begin
      clear_ring();
      retire_width = RETIRE_WIDTH_RST;
      pending_words.delete();
    end else begin
      if (result_valid && result_ready) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result word, expected none, got %h", $time, result);
        end else begin
          want = pending_words.pop_front();
          check_field("out_kind",          want.out_kind,          result.out_kind);
          check_field("out_inst_id",       want.out_inst_id,       result.out_inst_id);
          check_field("slot_tag",          want.slot_tag,          result.slot_tag);
          check_field("retired_is_branch", want.retired_is_branch, result.retired_is_branch);
          check_field("redirect",          want.redirect,          result.redirect);
          check_field("credit",            want.credit,            result.credit);
          check_field("overflow",          want.overflow,          result.overflow);
          check_field("last",              want.last,              result.last);
        end
      end
      if (item_valid && item_ready) begin
        items_seen++;
        predict_words(item);
      end
      if (cfg_valid && cfg_ready) retire_width = cfg_data;
    end
    outstanding <= pending_words.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reorder buffer: directed allocate, finish,
// commit and flush sequences, then phases of random episodes under a range of
// retire widths, with random idling on both channels and one long stall.
// ----------------------------------------------------------------------------
module tb;
  import rbc_pkg::*;

  localparam int SETTLE_CYCLES = 40;     // covers the longest commit walk
  localparam int LONG_HOLD     = 300;    // result stall that backs up the input
  localparam int PHASE_ITEMS   = 12;
  localparam int NUM_PHASES    = 8;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  rbc_item_t   item;
  logic        result_valid;
  logic        result_ready;
  rbc_result_t result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  int mismatches;
  int outstanding;
  int items_seen;
  int words_seen;
  int overflows_seen;
  int redirects_seen;
  int wakeups_seen;

  // stimulus-side view of the ring, only good enough to aim finishes at
  // live slots and to know when the buffer is full
  int ring_tail;
  int ring_fill;
  int cur_width;
  int sent;
  int live_tags [$];

  bit quiet;         // no idling on either side
  bit hold_off_go;   // ask the result side for one long stall

  reorder_buffer_commit u_top (.*);

  rbc_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random bursts of back-pressure, one long hold-off on request,
  // and none at all once the run turns quiet.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall;
    bit held;
    stall        = 0;
    held         = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !held) begin
        // hold results back long enough that the block stops taking items
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic rbc_item_t make_word(int kind, int id, int st, int br, int tag,
                                          int misp);
    rbc_item_t w;
    w.kind         = 2'(kind);
    w.inst_id      = 16'(id);
    w.is_store     = 1'(st);
    w.is_branch    = 1'(br);
    w.finish_tag   = TAG_W'(tag);
    w.mispredicted = 1'(misp);
    return w;
  endfunction

  // Offer one item word and hold it until taken. Valid stays high on return,
  // so the next call either replaces the payload or drops valid for a gap.
  task automatic send_word(input rbc_item_t w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= w;
    // advance the stimulus view of the ring
    sent++;
    case (w.kind)
      KIND_ALLOC: begin
        if (ring_fill < ROB_DEPTH) begin
          ring_tail = (ring_tail + 1) % ROB_DEPTH;
          ring_fill++;
        end
      end
      KIND_FLUSH: begin
        ring_tail = 0;
        ring_fill = 0;
      end
      default: ;
    endcase
    do @(posedge clk); while (!item_ready);
  endtask

  // finish one live slot picked at random
  task automatic finish_live(input bit misp);
    int j;
    int tag;
    j   = $urandom_range(0, live_tags.size() - 1);
    tag = live_tags[j];
    live_tags.delete(j);
    send_word(make_word(KIND_FINISH, 0, 0, 0, tag, misp));
  endtask

  // drop valid, wait for every expected word, then let the block settle
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0] widths [NUM_PHASES];
    int         p;
    int         i;
    int         k;
    int         n;
    int         weff;
    int         phase_end;
    int         start;
    int         pick;
    bit         bad;

    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    quiet       = 1'b0;
    hold_off_go = 1'b0;
    ring_tail   = 0;
    ring_fill   = 0;
    cur_width   = RETIRE_WIDTH_RST;
    sent        = 0;
    widths = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd9, 4'd2, 4'($urandom_range(1, 15))};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, retire width at its reset value of 4 ----
    // commit on an empty buffer: summary only, credit 0
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    // finish an unoccupied slot; the next allocate of slot 0 must clear it
    send_word(make_word(KIND_FINISH, 0, 0, 0, 0, 1));
    send_word(make_word(KIND_ALLOC, 16'hFFFF, 1, 1, 0, 0));
    send_word(make_word(KIND_ALLOC, 16'h0000, 0, 0, 0, 0));
    send_word(make_word(KIND_ALLOC, 16'h5A5A, 1, 0, 0, 0));
    // head store not done: woken on the first commit only
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    // finish out of order, then retire both and wake the next store
    send_word(make_word(KIND_FINISH, 0, 0, 0, 1, 0));
    send_word(make_word(KIND_FINISH, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    // mispredicted head: reported with redirect on every commit, never popped
    send_word(make_word(KIND_FINISH, 0, 0, 0, 2, 1));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_FLUSH, 0, 0, 0, 0, 0));
    // five done entries against a width of four: two commits to empty
    for (i = 0; i < 5; i++)
      send_word(make_word(KIND_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 1),
                          $urandom_range(0, 1), 0, 0));
    for (i = 4; i >= 0; i--)
      send_word(make_word(KIND_FINISH, 0, 0, 0, i, 0));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
    ring_fill = 0;

    // ---- random part: one retire width per phase ----
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= widths[p];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid <= 1'b0;
      cur_width = widths[p];
      weff      = (cur_width > MAX_RETIRE) ? MAX_RETIRE : cur_width;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      if (p == 2) hold_off_go = 1'b1;

      if (p == 1) begin
        // fill the ring, overflow twice, free the head, refill past full
        start = ring_tail;
        repeat (ROB_DEPTH + 2)
          send_word(make_word(KIND_ALLOC, $urandom_range(0, 65535),
                              $urandom_range(0, 1), $urandom_range(0, 1), 0, 0));
        send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
        send_word(make_word(KIND_FINISH, 0, 0, 0, start, 0));
        send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
        ring_fill--;
        send_word(make_word(KIND_ALLOC, $urandom_range(0, 65535), 1, 0, 0, 0));
        send_word(make_word(KIND_ALLOC, $urandom_range(0, 65535), 0, 1, 0, 0));
        send_word(make_word(KIND_FLUSH, 0, 0, 0, 0, 0));
      end

      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // well-formed episode: allocate, finish in any order, commit empty
          k = $urandom_range(1, 10);
          live_tags.delete();
          for (i = 0; i < k; i++) begin
            live_tags.push_back(ring_tail);
            send_word(make_word(KIND_ALLOC, $urandom_range(0, 65535),
                                $urandom_range(0, 9) < 4, $urandom_range(0, 9) < 3, 0, 0));
            if ($urandom_range(0, 3) == 0) finish_live(1'b0);
            if ($urandom_range(0, 3) == 0)
              send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
          end
          bad = ($urandom_range(0, 4) == 0);
          while (live_tags.size() > 0)
            finish_live(bad && $urandom_range(0, live_tags.size() - 1) == 0);
          n = (weff == 0) ? 2 : (k + weff - 1) / weff + 1;
          repeat (n) send_word(make_word(KIND_COMMIT, 0, 0, 0, 0, 0));
          // a redirect, or a width that retires nothing, leaves entries behind
          if (bad || weff == 0) send_word(make_word(KIND_FLUSH, 0, 0, 0, 0, 0));
          else ring_fill = 0;
        end else begin
          // noise: any kind with any fields, then clean up with a flush
          repeat ($urandom_range(1, 6))
            send_word(make_word($urandom_range(0, 3), $urandom_range(0, 65535),
                                $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 63), $urandom_range(0, 1)));
          send_word(make_word(KIND_FLUSH, 0, 0, 0, 0, 0));
        end
      end
    end

    drain();
    $display("Checked %0d result words from %0d items: %0d full-buffer allocates,",
             words_seen, items_seen, overflows_seen);
    $display("%0d redirects, %0d store wakeups; retire widths 0 to 15 (final %0d) set.",
             redirects_seen, wakeups_seen, cur_width);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/rbc_pkg.sv
rtl/rbc_ram.sv
rtl/rbc_ctrl.sv
rtl/reorder_buffer_commit.sv
verif/rbc_checker.sv
verif/tb.sv
